@@ design/sorted_array_set_unit_macros.svh @@
// Assertion macros used by sas_checker, the checking file of the sorted array set unit.
`ifndef SORTED_ARRAY_SET_UNIT_MACROS_SVH
`define SORTED_ARRAY_SET_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted array set check failed");

// The consequent must hold in the cycle after the antecedent.
`define SAS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted array set check failed");

`endif

@@ design/sas_pkg.sv @@
package sas_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 7;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_LOOKUP = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic cmp;
		logic ins;
		logic del;
	} cell_ctrl_t;

endpackage

@@ design/sas_cell.sv @@
module sas_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sas_pkg::cell_ctrl_t               ctrl,
	input  logic signed [sas_pkg::VALUE_W-1:0] value,
	input  logic                              occ,
	input  logic        [sas_pkg::VALUE_W-1:0] left_entry,
	input  logic                              left_after,
	input  logic        [sas_pkg::VALUE_W-1:0] right_entry,
	output logic        [sas_pkg::VALUE_W-1:0] entry,
	output logic                              after,
	output logic                              match
);

	logic [sas_pkg::VALUE_W-1:0] entry_q;
	logic                        after_q;
	logic                        match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_q <= 1'b0;
			match_q <= 1'b0;
		end else if (ctrl.cmp) begin
			after_q <= !occ || ($signed(entry_q) >= value);
			match_q <= occ && (entry_q == value);
		end
	end

	// A cell at or beyond the ceiling position takes part in the shift.
	always_ff @(posedge clk) begin
		if (ctrl.ins && after_q) begin
			entry_q <= left_after ? left_entry : value;
		end else if (ctrl.del && after_q) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;
	assign after = after_q;
	assign match = match_q;

endmodule

@@ design/sorted_array_set_unit.sv @@
// Sorted array set unit.
// Keeps a set of distinct signed 32-bit values in ascending order in a row of
// CAPACITY cells, each holding one entry next to its neighbours.
// The request channel (req_valid, req_stall, kind, value) carries one
// operation: insert, delete or membership test. The response channel
// (rsp_valid, rsp_stall, was_present, rejected_full, count) returns exactly
// one result for each request, in order.
// After a request transfer, the compare state compares every cell with the
// value at once and the update state shifts the cells and loads the response
// register. A new request is taken in the same cycle as the shift, so none
// is taken while the last one is still being compared; the compare and shift
// steps through the cell row set this pace.
// When the receiver stalls, the finished response is held in the output
// register; a request already taken is compared, its shift waits until the
// response register is free, and no further request is taken meanwhile.
// Reset empties the set and clears the response valid flag; no clearing pass is
// needed, as only entries below the count are ever read.
module sorted_array_set_unit #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic        [1:0]                  kind,
	input  logic signed [sas_pkg::VALUE_W-1:0] value,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic                               was_present,
	output logic                               rejected_full,
	output logic        [sas_pkg::COUNT_W-1:0] count
);

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	sas_pkg::state_t                    state_q;
	sas_pkg::state_t                    state_d;
	logic        [1:0]                  kind_q;
	logic signed [sas_pkg::VALUE_W-1:0] value_q;
	logic        [CNT_W-1:0]            count_q;
	logic                               rsp_valid_q;
	logic                               was_present_q;
	logic                               rejected_full_q;
	logic        [sas_pkg::COUNT_W-1:0] count_out_q;

	sas_pkg::cell_ctrl_t         ctrl;
	logic [sas_pkg::VALUE_W-1:0] entry_w [CAPACITY];
	logic [CAPACITY-1:0]         after_w;
	logic [CAPACITY-1:0]         match_w;

	logic rsp_free;
	logic req_take;
	logic finish;
	logic present;
	logic full;
	logic ins_do;
	logic del_do;

	assign rsp_free = !rsp_valid_q || !rsp_stall;
	assign req_take = req_valid && !req_stall;
	assign finish   = (state_q == sas_pkg::ST_UPD) && rsp_free;
	assign present  = |match_w;
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign ins_do   = (kind_q == sas_pkg::KIND_INSERT) && !present && !full;
	assign del_do   = (kind_q == sas_pkg::KIND_DELETE) && present;

	always_comb begin
		state_d = state_q;
		case (state_q)
			sas_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = sas_pkg::ST_CMP;
				end
			end
			sas_pkg::ST_CMP: begin
				state_d = sas_pkg::ST_UPD;
			end
			sas_pkg::ST_UPD: begin
				if (rsp_free) begin
					state_d = req_valid ? sas_pkg::ST_CMP : sas_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sas_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall = 1'b1;
		ctrl      = '0;
		case (state_q)
			sas_pkg::ST_IDLE: begin
				req_stall = 1'b0;
			end
			sas_pkg::ST_CMP: begin
				ctrl.cmp = 1'b1;
			end
			sas_pkg::ST_UPD: begin
				req_stall = !rsp_free;
				ctrl.ins  = rsp_free && ins_do;
				ctrl.del  = rsp_free && del_do;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sas_pkg::ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (finish) begin
				rsp_valid_q <= 1'b1;
				if (ins_do) begin
					count_q <= count_q + CNT_W'(1);
				end else if (del_do) begin
					count_q <= count_q - CNT_W'(1);
				end
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			kind_q  <= kind;
			value_q <= value;
		end
		if (finish) begin
			was_present_q   <= present;
			rejected_full_q <= (kind_q == sas_pkg::KIND_INSERT) && !present && full;
			if (ins_do) begin
				count_out_q <= sas_pkg::COUNT_W'(count_q + CNT_W'(1));
			end else if (del_do) begin
				count_out_q <= sas_pkg::COUNT_W'(count_q - CNT_W'(1));
			end else begin
				count_out_q <= sas_pkg::COUNT_W'(count_q);
			end
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [sas_pkg::VALUE_W-1:0] left_entry;
		logic                        left_after;
		logic [sas_pkg::VALUE_W-1:0] right_entry;
		logic                        occ;

		if (i == 0) begin : g_first
			assign left_entry = entry_w[i];
			assign left_after = 1'b0;
		end else begin : g_inner
			assign left_entry = entry_w[i-1];
			assign left_after = after_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_entry = entry_w[i];
		end else begin : g_body
			assign right_entry = entry_w[i+1];
		end

		assign occ = (CNT_W'(i) < count_q);

		sas_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.value       (value_q),
			.occ         (occ),
			.left_entry  (left_entry),
			.left_after  (left_after),
			.right_entry (right_entry),
			.entry       (entry_w[i]),
			.after       (after_w[i]),
			.match       (match_w[i])
		);
	end

	assign rsp_valid     = rsp_valid_q;
	assign was_present   = was_present_q;
	assign rejected_full = rejected_full_q;
	assign count         = count_out_q;

endmodule

@@ design/sas_checker.sv @@
`include "sorted_array_set_unit_macros.svh"

module sas_checker #(
	parameter int unsigned CAPACITY = 64
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               req_valid,
	input logic                               req_stall,
	input logic        [1:0]                  kind,
	input logic signed [sas_pkg::VALUE_W-1:0] value,
	input logic                               rsp_valid,
	input logic                               rsp_stall,
	input logic                               was_present,
	input logic                               rejected_full,
	input logic        [sas_pkg::COUNT_W-1:0] count
);

	logic req_xfer;
	logic req_wait;
	logic held;

	assign req_xfer = req_valid && !req_stall;
	assign req_wait = req_valid && req_stall;
	assign held     = rsp_valid && rsp_stall;

	`SAS_ASSERT_NEXT(a_rsp_hold, held,
		rsp_valid && $stable(was_present) && $stable(rejected_full) && $stable(count))
	`SAS_ASSERT_NEXT(a_req_hold, req_wait, req_valid && $stable(kind) && $stable(value))
	`SAS_ASSERT_NEXT(a_busy_after_req, req_xfer, req_stall)
	`SAS_ASSERT_NOW(a_reject_absent, rsp_valid && rejected_full, !was_present)
	`SAS_ASSERT_NOW(a_reject_full_count, rsp_valid && rejected_full,
		count == sas_pkg::COUNT_W'(CAPACITY))

endmodule

bind sorted_array_set_unit sas_checker #(.CAPACITY(CAPACITY)) u_sas_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req_valid),
	.req_stall     (req_stall),
	.kind          (kind),
	.value         (value),
	.rsp_valid     (rsp_valid),
	.rsp_stall     (rsp_stall),
	.was_present   (was_present),
	.rejected_full (rejected_full),
	.count         (count)
);

@@ tb/tb.sv @@
module tb;

	localparam int CAPACITY = 64;
	localparam int POOL_SIZE = 96;
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic signed [sas_pkg::VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
	localparam logic signed [sas_pkg::VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic                        was_present;
		logic                        rejected_full;
		logic [sas_pkg::COUNT_W-1:0] count;
	} set_result_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               req_valid = 1'b0;
	logic                               req_stall;
	logic [1:0]                         kind = sas_pkg::KIND_LOOKUP;
	logic signed [sas_pkg::VALUE_W-1:0] value = '0;
	logic                               rsp_valid;
	logic                               rsp_stall = 1'b0;
	logic                               was_present;
	logic                               rejected_full;
	logic [sas_pkg::COUNT_W-1:0]        count;

	logic signed [sas_pkg::VALUE_W-1:0] held_values [CAPACITY];
	int                                 held_count = 0;
	set_result_t                        pending_results [$];
	logic signed [sas_pkg::VALUE_W-1:0] value_pool [POOL_SIZE];

	int sender_idle_pct = 0;
	int receiver_idle_pct = 0;
	int hold_off_request = 0;
	int hold_off_left = 0;
	int quiet_cycles = 0;
	int mismatches = 0;
	int ops_sent = 0;
	int inserts_added = 0;
	int inserts_refused = 0;
	int found_present = 0;
	int peak_count = 0;
	int input_stall_cycles = 0;

	sorted_array_set_unit #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.kind         (kind),
		.value        (value),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.was_present  (was_present),
		.rejected_full(rejected_full),
		.count        (count)
	);

	always #2 clk = ~clk;

	function automatic set_result_t apply_set_op(input logic [1:0] op,
			input logic signed [sas_pkg::VALUE_W-1:0] v);
		set_result_t res;
		int pos;
		logic present;
		res = '0;
		pos = 0;
		while (pos < held_count && held_values[pos] < v)
			pos++;
		present = (pos < held_count) && (held_values[pos] == v);
		if (op == sas_pkg::KIND_INSERT && !present) begin
			if (held_count >= CAPACITY) begin
				res.rejected_full = 1'b1;
			end else begin
				for (int i = held_count; i > pos; i--)
					held_values[i] = held_values[i - 1];
				held_values[pos] = v;
				held_count++;
			end
		end else if (op == sas_pkg::KIND_DELETE && present) begin
			for (int i = pos; i + 1 < held_count; i++)
				held_values[i] = held_values[i + 1];
			held_count--;
		end
		res.was_present = present;
		res.count = held_count[sas_pkg::COUNT_W-1:0];
		return res;
	endfunction

	// Results are retired before the new request is predicted: no result can
	// belong to a request taken at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result with nothing outstanding: was_present %0b "
						, $time, was_present, "rejected_full %0b count %0d",
						rejected_full, count);
					mismatches++;
				end else begin
					set_result_t exp_res;
					exp_res = pending_results.pop_front();
					if (exp_res.was_present !== was_present) begin
						$display("%0t: was_present expected %0b actual %0b", $time,
							exp_res.was_present, was_present);
						mismatches++;
					end
					if (exp_res.rejected_full !== rejected_full) begin
						$display("%0t: rejected_full expected %0b actual %0b", $time,
							exp_res.rejected_full, rejected_full);
						mismatches++;
					end
					if (exp_res.count !== count) begin
						$display("%0t: count expected %0d actual %0d", $time,
							exp_res.count, count);
						mismatches++;
					end
				end
			end
			if (req_valid && req_stall)
				input_stall_cycles++;
			if (req_valid && !req_stall) begin
				set_result_t res;
				res = apply_set_op(kind, value);
				pending_results.push_back(res);
				ops_sent++;
				if (kind == sas_pkg::KIND_INSERT && !res.was_present && !res.rejected_full)
					inserts_added++;
				if (res.rejected_full)
					inserts_refused++;
				if (res.was_present)
					found_present++;
				if (held_count > peak_count)
					peak_count = held_count;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_off_request > 0) begin
			hold_off_left = hold_off_request;
			hold_off_request = 0;
		end
		if (hold_off_left > 0) begin
			hold_off_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
				$display("FAIL sorted_array_set_unit");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [1:0] op,
			input logic signed [sas_pkg::VALUE_W-1:0] v);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		kind <= op;
		value <= v;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic void refill_pool();
		value_pool[0] = VALUE_MIN;
		value_pool[1] = VALUE_MIN + 1;
		value_pool[2] = -1;
		value_pool[3] = 0;
		value_pool[4] = 1;
		value_pool[5] = VALUE_MAX - 1;
		value_pool[6] = VALUE_MAX;
		for (int i = 7; i < POOL_SIZE; i++)
			value_pool[i] = $urandom;
	endfunction

	task automatic test_directed();
		send_item(sas_pkg::KIND_LOOKUP, 0);
		send_item(sas_pkg::KIND_DELETE, 5);
		send_item(sas_pkg::KIND_INSERT, 0);
		send_item(sas_pkg::KIND_INSERT, VALUE_MAX);
		send_item(sas_pkg::KIND_INSERT, VALUE_MIN);
		send_item(sas_pkg::KIND_INSERT, -1);
		send_item(sas_pkg::KIND_INSERT, 1);
		send_item(sas_pkg::KIND_INSERT, 0);
		send_item(sas_pkg::KIND_LOOKUP, VALUE_MIN);
		send_item(sas_pkg::KIND_LOOKUP, VALUE_MAX);
		send_item(KIND_UNUSED, -1);
		send_item(KIND_UNUSED, 2);
		send_item(sas_pkg::KIND_LOOKUP, 2);
		send_item(sas_pkg::KIND_DELETE, VALUE_MIN);
		send_item(sas_pkg::KIND_DELETE, VALUE_MAX);
		send_item(sas_pkg::KIND_DELETE, 0);
		send_item(sas_pkg::KIND_DELETE, 0);
		send_item(sas_pkg::KIND_INSERT, 32'sh5555_5555);
		send_item(sas_pkg::KIND_INSERT, 32'shaaaa_aaaa);
		send_item(sas_pkg::KIND_DELETE, -1);
		send_item(sas_pkg::KIND_DELETE, 1);
		send_item(sas_pkg::KIND_DELETE, 32'sh5555_5555);
		send_item(sas_pkg::KIND_DELETE, 32'shaaaa_aaaa);
		drain_results();
	endtask

	// The top six bits make every fill value distinct, so flipping a low bit
	// gives a value that is certainly absent.
	task automatic test_full_set();
		logic signed [sas_pkg::VALUE_W-1:0] fill_values [CAPACITY];
		logic signed [sas_pkg::VALUE_W-1:0] swap;
		logic signed [sas_pkg::VALUE_W-1:0] absent;
		int j;
		for (int i = 0; i < CAPACITY; i++) begin
			fill_values[i] = $urandom;
			fill_values[i][sas_pkg::VALUE_W-1 -: 6] = i[5:0];
		end
		for (int i = CAPACITY - 1; i > 0; i--) begin
			j = $urandom_range(i);
			swap = fill_values[i];
			fill_values[i] = fill_values[j];
			fill_values[j] = swap;
		end
		absent = fill_values[0] ^ 1;
		for (int i = 0; i < CAPACITY; i++)
			send_item(sas_pkg::KIND_INSERT, fill_values[i]);
		send_item(sas_pkg::KIND_INSERT, absent);
		send_item(sas_pkg::KIND_INSERT, fill_values[5]);
		send_item(sas_pkg::KIND_LOOKUP, absent);
		send_item(KIND_UNUSED, fill_values[7]);
		send_item(sas_pkg::KIND_DELETE, fill_values[3]);
		send_item(sas_pkg::KIND_INSERT, absent);
		send_item(sas_pkg::KIND_INSERT, fill_values[3]);
		for (int i = 0; i < CAPACITY; i++)
			send_item(sas_pkg::KIND_DELETE, fill_values[i]);
		send_item(sas_pkg::KIND_DELETE, absent);
		drain_results();
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering, so the held response blocks the output and the block stalls its input.
	task automatic test_backpressure();
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		refill_pool();
		@(posedge clk);
		hold_off_request = HOLD_OFF_CYCLES;
		@(negedge clk);
		for (int i = 0; i < 40; i++) begin
			if (i[0])
				send_item(sas_pkg::KIND_LOOKUP,
					value_pool[$urandom_range(POOL_SIZE - 1)]);
			else
				send_item(sas_pkg::KIND_INSERT,
					value_pool[$urandom_range(POOL_SIZE - 1)]);
		end
		drain_results();
	endtask

	// Each run picks at random a filling, balanced or emptying mix so that the
	// occupancy sweeps between empty and full.
	task automatic run_random_phase(input int n_ops, input int s_pct, input int r_pct);
		int done;
		int run_len;
		int insert_pct;
		int roll;
		logic [1:0] op;
		logic signed [sas_pkg::VALUE_W-1:0] v;
		sender_idle_pct = s_pct;
		receiver_idle_pct = r_pct;
		refill_pool();
		done = 0;
		while (done < n_ops) begin
			run_len = $urandom_range(100, 40);
			case ($urandom_range(2))
				0: begin
					insert_pct = 80;
				end
				1: begin
					insert_pct = 45;
				end
				default: begin
					insert_pct = 15;
				end
			endcase
			for (int i = 0; i < run_len && done < n_ops; i++) begin
				roll = $urandom_range(99);
				if (roll < insert_pct)
					op = sas_pkg::KIND_INSERT;
				else if (roll >= 97)
					op = KIND_UNUSED;
				else if (roll[0])
					op = sas_pkg::KIND_DELETE;
				else
					op = sas_pkg::KIND_LOOKUP;
				if ($urandom_range(9) == 0)
					v = $urandom;
				else
					v = value_pool[$urandom_range(POOL_SIZE - 1)];
				send_item(op, v);
				done++;
			end
		end
		drain_results();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		sender_idle_pct = 16;
		receiver_idle_pct = 46;
		test_directed();
		test_full_set();
		run_random_phase(600, 16, 46);
		run_random_phase(600, 46, 16);
		run_random_phase(600, 0, 0);
		test_backpressure();
		repeat (8) @(posedge clk);
		$display("Ran %0d operations: %0d inserts stored, %0d refused at capacity,",
			ops_sent, inserts_added, inserts_refused);
		$display("%0d hits on present values, peak occupancy %0d, %0d input stall cycles.",
			found_present, peak_count, input_stall_cycles);
		if (mismatches == 0)
			$display("PASS sorted_array_set_unit");
		else
			$display("FAIL sorted_array_set_unit");
		$finish;
	end

endmodule

@@ sorted_array_set_unit.f @@
+incdir+design
design/sas_pkg.sv
design/sas_cell.sv
design/sorted_array_set_unit.sv
design/sas_checker.sv
tb/tb.sv
